// ===== sv/rlebe_pkg.sv =====
// rlebe_pkg: beat types, run-state constants and the run token helper
// for the run-length byte encoder; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rlebe_pkg;

   // run length register width, holds lengths up to 255
   localparam int RUN_LEN_W = 8;
   // default longest run before a forced break
   localparam int RLE_MAX_RUN = 128;
   // most encoded bytes that one input beat can cause
   localparam int MAX_CODES = 4;
   localparam int CODE_CNT_W = 3;
   // runs of one byte below this value go out as a literal
   localparam logic [7:0] LITERAL_LIMIT = 8'd128;
   // run token is the length plus this offset
   localparam logic [7:0] TOKEN_OFFSET = 8'd127;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       stream_last;
   } req_type;

   typedef struct packed {
      logic [7:0] code_byte;
      logic       item_last;
      logic       stream_end;
   } rsp_type;

   // one closed run as one or two code bytes
   typedef struct packed {
      logic       two;
      logic [7:0] b0;
      logic [7:0] b1;
   } token_type;

   // everything one input beat emits, head first
   typedef struct packed {
      logic [CODE_CNT_W-1:0]  count;
      rsp_type [MAX_CODES-1:0] slot;
   } plan_type;

   // encode a closed run: literal, or length token then value
   function automatic token_type run_token(input logic [7:0] value,
                                          input logic [RUN_LEN_W-1:0] len);
      token_type t;
      if (len == RUN_LEN_W'(1) && value < LITERAL_LIMIT) begin
         t.two = 1'b0;
         t.b0  = value;
         t.b1  = value;
      end else begin
         t.two = 1'b1;
         t.b0  = 8'(len) + TOKEN_OFFSET;
         t.b1  = value;
      end
      return t;
   endfunction

endpackage

`default_nettype wire

// ===== sv/rlebe_run.sv =====
// rlebe_run: open run register and the emission plan for one input beat
// depends on rlebe_pkg
`timescale 1ns / 1ps
`default_nettype none

module rlebe_run #(
   parameter int MAX_RUN = rlebe_pkg::RLE_MAX_RUN
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   accept,
   input  rlebe_pkg::req_type    beat,
   output rlebe_pkg::plan_type   plan
);
   import rlebe_pkg::*;

   localparam logic [RUN_LEN_W-1:0] MaxRunLen = RUN_LEN_W'(MAX_RUN);

   logic [7:0]           run_val_ff, run_val_in;
   logic [RUN_LEN_W-1:0] run_len_ff, run_len_in;

   logic                  cont, brk;
   token_type             tok_a, tok_b;
   logic [CODE_CNT_W-1:0] n1, n2, cnt;
   logic [7:0]            new_val;
   logic [RUN_LEN_W-1:0]  new_len;
   logic [CODE_CNT_W-1:0] pos;

   // decide run extension or break, and lay out the code bytes
   always_comb begin
      cont    = (run_len_ff != '0) && (beat.data_byte == run_val_ff) &&
                (run_len_ff < MaxRunLen);
      brk     = (run_len_ff != '0) && !cont;
      tok_a   = run_token(run_val_ff, run_len_ff);
      n1      = brk ? (tok_a.two ? CODE_CNT_W'(2) : CODE_CNT_W'(1)) : '0;
      new_val = cont ? run_val_ff : beat.data_byte;
      new_len = cont ? run_len_ff + RUN_LEN_W'(1) : RUN_LEN_W'(1);
      tok_b   = run_token(new_val, new_len);
      n2      = beat.stream_last ? (tok_b.two ? CODE_CNT_W'(2) : CODE_CNT_W'(1)) : '0;
      cnt     = n1 + n2;
      plan.count = cnt;
      for (int i = 0; i < MAX_CODES; i++) begin
         pos = CODE_CNT_W'(i);
         if (pos < n1)
            plan.slot[i].code_byte = (i == 0) ? tok_a.b0 : tok_a.b1;
         else if (pos - n1 == '0)
            plan.slot[i].code_byte = tok_b.b0;
         else
            plan.slot[i].code_byte = tok_b.b1;
         plan.slot[i].item_last  = (pos + CODE_CNT_W'(1) == cnt);
         plan.slot[i].stream_end = beat.stream_last && (pos + CODE_CNT_W'(1) == cnt);
      end
      run_val_in = new_val;
      run_len_in = beat.stream_last ? '0 : new_len;
   end

   // open run register
   always_ff @(posedge clock) begin
      if (reset) begin
         run_val_ff <= '0;
         run_len_ff <= '0;
      end else if (accept) begin
         run_val_ff <= run_val_in;
         run_len_ff <= run_len_in;
      end
   end

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      run_len_ff <= MaxRunLen)
      else $error("run length beyond limit");

   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      accept && beat.stream_last |=> run_len_ff == '0)
      else $error("stream end left a run open");

   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      accept && beat.stream_last |-> plan.count != '0)
      else $error("stream end emitted nothing");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      plan.count <= CODE_CNT_W'(MAX_CODES))
      else $error("plan count too large");

endmodule

`default_nettype wire

// ===== sv/rle_byte_encoder_core.sv =====
// Run-length byte encoder. One raw byte is taken per input beat; a byte that
// breaks the open run (or meets a full run of MAX_RUN bytes) emits that run as
// a literal byte below 128 or as a token (length + 127) followed by the value,
// and a beat flagged stream_last flushes the open run with stream_end set on
// its final byte. Each beat causes 0 to 4 code bytes, delivered one per cycle
// while rsp_stall is low, from a four-entry holding buffer behind a registered
// output; an input beat is taken once the buffer has drained to its last byte
// and that byte is leaving, so a new beat can be accepted as the last one ends.
// depends on rlebe_pkg, rlebe_run
`timescale 1ns / 1ps
`default_nettype none

module rle_byte_encoder_core #(
   parameter int MAX_RUN = rlebe_pkg::RLE_MAX_RUN
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  rlebe_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output rlebe_pkg::rsp_type  rsp_data
);
   import rlebe_pkg::*;

   plan_type                plan;
   logic                    req_acc;
   logic                    out_free;
   logic                    take;
   rsp_type [MAX_CODES-1:0] slot_ff, slot_in;
   logic [CODE_CNT_W-1:0]   rem_ff, rem_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_beat_ff, rsp_beat_in;

   rlebe_run #(.MAX_RUN(MAX_RUN)) u_run (
      .clock  (clock),
      .reset  (reset),
      .accept (req_acc),
      .beat   (req_data),
      .plan   (plan)
   );

   // handshake: output register frees when empty or when its beat leaves
   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      take      = (rem_ff != '0) && out_free;
      req_stall = (rem_ff > CODE_CNT_W'(1)) || ((rem_ff == CODE_CNT_W'(1)) && !out_free);
      req_acc   = req_valid && !req_stall;
   end

   // holding buffer: load a new plan or shift toward the head
   always_comb begin
      slot_in = slot_ff;
      rem_in  = rem_ff;
      if (req_acc) begin
         slot_in = plan.slot;
         rem_in  = plan.count;
      end else if (take) begin
         for (int i = 0; i < MAX_CODES - 1; i++)
            slot_in[i] = slot_ff[i+1];
         rem_in = rem_ff - CODE_CNT_W'(1);
      end
   end

   // output register next value
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_beat_in  = rsp_beat_ff;
      if (out_free) begin
         rsp_valid_in = rem_ff != '0;
         rsp_beat_in  = slot_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      rsp_beat_ff <= rsp_beat_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_beat_ff;

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      rem_ff <= CODE_CNT_W'(MAX_CODES))
      else $error("holding buffer overfilled");

   a_head_not_last: assert property (@(posedge clock) disable iff (reset)
      rem_ff > CODE_CNT_W'(1) |-> !slot_ff[0].item_last)
      else $error("item end flagged before the last buffered byte");

   a_drain_moves: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_valid_ff)
      else $error("buffered byte lost on its way out");

   a_end_is_item_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_beat_ff.stream_end |-> rsp_beat_ff.item_last)
      else $error("stream end without item end");

endmodule

`default_nettype wire

// ===== verif/rle_code_checker.sv =====
`timescale 1ns / 1ps
// rle_code_checker: watches both channels of the run-length byte encoder, predicts
// the code bytes of every accepted input beat and compares them in order
// depends on rlebe_pkg
module rle_code_checker
   import rlebe_pkg::*;
#(
   parameter int MAX_RUN = RLE_MAX_RUN
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending,
   output int      codes_checked
);

   // predicted run state
   logic [7:0] run_val;
   int         run_len;
   // code bytes produced by the beat being predicted
   rsp_type    beat_codes [MAX_CODES];
   int         n_codes;
   // expected code bytes, oldest first
   rsp_type    code_queue [$];
   int         mismatches = 0;
   int         matched = 0;

   // close the open run into beat_codes: literal, or length token then value
   function automatic void close_run();
      if (run_len == 1 && run_val < LITERAL_LIMIT) begin
         beat_codes[n_codes] = '{code_byte: run_val, item_last: 1'b0, stream_end: 1'b0};
         n_codes++;
      end else begin
         beat_codes[n_codes] = '{code_byte: 8'(run_len) + TOKEN_OFFSET,
                                 item_last: 1'b0, stream_end: 1'b0};
         beat_codes[n_codes + 1] = '{code_byte: run_val, item_last: 1'b0, stream_end: 1'b0};
         n_codes += 2;
      end
   endfunction

   // advance the run state by one raw byte and queue the code bytes it causes
   task automatic predict_codes(input req_type beat);
      n_codes = 0;
      if (run_len == 0) begin
         run_val = beat.data_byte;
         run_len = 1;
      end else if (beat.data_byte == run_val && run_len < MAX_RUN) begin
         run_len++;
      end else begin
         close_run();
         run_val = beat.data_byte;
         run_len = 1;
      end
      // end of stream flushes the open run
      if (beat.stream_last) begin
         close_run();
         run_len = 0;
         beat_codes[n_codes - 1].stream_end = 1'b1;
      end
      if (n_codes > 0) begin
         beat_codes[n_codes - 1].item_last = 1'b1;
      end
      for (int i = 0; i < n_codes; i++) begin
         code_queue = {code_queue, beat_codes[i]};
      end
   endtask

   // compare one output beat with the oldest expectation
   task automatic check_code(input rsp_type got);
      rsp_type want;
      if (code_queue.size() == 0) begin
         if (mismatches < 10) begin
            $display("%0t: code beat with nothing expected: code=%02h last=%b end=%b",
                     $realtime, got.code_byte, got.item_last, got.stream_end);
         end
         mismatches++;
      end else begin
         want = code_queue.pop_front();
         if (got.code_byte !== want.code_byte || got.item_last !== want.item_last ||
             got.stream_end !== want.stream_end) begin
            if (mismatches < 10) begin
               $display("%0t: code mismatch: expected %02h/%b/%b, got %02h/%b/%b",
                        $realtime, want.code_byte, want.item_last, want.stream_end,
                        got.code_byte, got.item_last, got.stream_end);
            end
            mismatches++;
         end
         matched++;
      end
   endtask

   // sample both channels at the clock edge
   always @(posedge clock) begin
      if (reset) begin
         run_val = '0;
         run_len = 0;
         code_queue.delete();
      end else begin
         if (req_valid && !req_stall) begin
            predict_codes(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            check_code(rsp_data);
         end
      end
      fail_count    <= mismatches;
      pending       <= code_queue.size();
      codes_checked <= matched;
   end

endmodule

// ===== verif/tb_rle_byte_encoder_core.sv =====
`timescale 1ns / 1ps
// tb_rle_byte_encoder_core: drives byte streams into the run-length encoder and
// stalls its output at random; checking is done by rle_code_checker
// depends on rlebe_pkg, rle_byte_encoder_core, rle_code_checker
module tb_rle_byte_encoder_core;
   import rlebe_pkg::*;

   localparam int HOLD_CYCLES = 80;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int fail_count;
   int pending;
   int codes_checked;

   // idling mix of the current phase
   int phase = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   bit held = 1'b0;
   int beats_sent = 0;
   int streams_sent = 0;

   rle_byte_encoder_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   rle_code_checker codes_chk (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending       (pending),
      .codes_checked (codes_checked)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // run byte values, biased towards the extremes and the literal limit
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(9))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h7F;
         3: return 8'h80;
         default: return 8'($urandom);
      endcase
   endfunction

   // offer one raw byte, with random idle cycles ahead of it
   task automatic send_beat(input logic [7:0] value, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{data_byte: value, stream_last: last};
      do @(posedge clock); while (req_stall);
      beats_sent++;
      if (last) begin
         streams_sent++;
      end
   endtask

   // stop offering until every expected code byte has come out
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // whole streams built from runs of random value and length
   task automatic send_random(input int budget);
      logic [7:0] stream_bytes [$];
      logic [7:0] value;
      int         length;
      int         pick;
      int         count;
      count = 0;
      while (count < budget) begin
         stream_bytes = {};
         repeat ($urandom_range(1, 8)) begin
            value = pick_byte();
            pick  = $urandom_range(99);
            if (pick < 45) length = 1;
            else if (pick < 75) length = 2;
            else if (pick < 92) length = $urandom_range(3, 6);
            else if (pick < 99) length = $urandom_range(7, 20);
            else length = $urandom_range(126, 131);
            repeat (length) stream_bytes = {stream_bytes, value};
         end
         foreach (stream_bytes[i]) begin
            send_beat(stream_bytes[i], i == stream_bytes.size() - 1);
         end
         count += stream_bytes.size();
      end
   endtask

   // output side: random stalls, one long hold-off when the last phase starts
   initial begin : receiver
      forever begin
         if (phase == 2 && !held) begin
            held = 1'b1;
            repeat (HOLD_CYCLES) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      logic [7:0] long_value;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // phase 0: sender idles lightly, receiver stalls half the time
      send_idle_pct = 18;
      stall_pct     = 50;
      // single-byte streams at the extremes and either side of the literal limit
      send_beat(8'h00, 1'b1);
      send_beat(8'hFF, 1'b1);
      send_beat(8'h7F, 1'b1);
      send_beat(8'h80, 1'b1);
      // run of three broken by a literal on the last beat
      send_beat(8'h41, 1'b0);
      send_beat(8'h41, 1'b0);
      send_beat(8'h41, 1'b0);
      send_beat(8'h42, 1'b1);
      // high single byte broken, then a run of two flushed
      send_beat(8'hC3, 1'b0);
      send_beat(8'h10, 1'b0);
      send_beat(8'h10, 1'b1);
      // two high single bytes: the last beat gives four code bytes
      send_beat(8'h90, 1'b0);
      send_beat(8'hA0, 1'b1);
      // alternating single bytes; AA is above the literal limit and goes out as a token
      send_beat(8'h55, 1'b0);
      send_beat(8'hAA, 1'b0);
      send_beat(8'h55, 1'b0);
      send_beat(8'h00, 1'b1);
      // runs of two at both extremes
      send_beat(8'hFF, 1'b0);
      send_beat(8'hFF, 1'b0);
      send_beat(8'h00, 1'b0);
      send_beat(8'h00, 1'b1);
      // 129 equal bytes: the full run is forced out and a new one opened
      long_value = pick_byte();
      for (int i = 0; i < 129; i++) begin
         send_beat(long_value, i == 128);
      end
      send_random(20);
      wait_drained();

      // phase 1: sender idles half the time, receiver stalls lightly
      phase         = 1;
      send_idle_pct = 50;
      stall_pct     = 18;
      send_random(60);
      wait_drained();

      // phase 2: no idling, apart from the long hold-off on the output
      phase         = 2;
      send_idle_pct = 0;
      stall_pct     = 0;
      send_random(60);
      wait_drained();
      repeat (20) @(posedge clock);

      $display("covered %0d streams, %0d raw bytes in, %0d code bytes compared",
               streams_sent, beats_sent, codes_checked);
      $display("with a forced full run, four-code beats and a %0d-cycle output hold-off",
               HOLD_CYCLES);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin : watchdog
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
